@@ rtl/crl_pkg.sv @@
package crl_pkg;

   localparam int FRAME_DEPTH_DEF   = 32;
   localparam int RECORD_LENGTH_DEF = 23;

   // frame bytes
   localparam logic [7:0] BYTE_REC_HEAD  = 8'hf0;
   localparam logic [7:0] BYTE_REC_TAIL  = 8'hfd;
   localparam logic [7:0] BYTE_CLOSE_FC  = 8'hfc;
   localparam logic [7:0] BYTE_ALT_HEAD  = 8'hb0;
   localparam logic [7:0] BYTE_END       = 8'hb4;
   localparam logic [7:0] BYTE_ECHO      = 8'hb7;
   localparam logic [7:0] BYTE_B8        = 8'hb8;
   localparam logic [7:0] BYTE_ACK       = 8'hb5;
   localparam logic [7:0] BYTE_NAK       = 8'hb2;
   localparam logic [7:0] BYTE_END_REPLY = 8'hb1;
   localparam logic [7:0] BYTE_END_IMM   = 8'hb7;

   localparam logic [3:0] END_REPLY_COUNT = 4'd9;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_SESSION = 1'b1;

   localparam logic CSR_END_MODE    = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   localparam logic [2:0] FST_GOOD   = 3'd0;
   localparam logic [2:0] FST_NAK    = 3'd1;
   localparam logic [2:0] FST_GIVEUP = 3'd2;
   localparam logic [2:0] FST_END    = 3'd3;
   localparam logic [2:0] FST_ERROR  = 3'd4;
   localparam logic [2:0] FST_ECHO   = 3'd5;

   typedef enum logic [2:0] {
      REPLY_GOOD   = 3'd0,
      REPLY_NAK    = 3'd1,
      REPLY_GIVEUP = 3'd2,
      REPLY_END    = 3'd3,
      REPLY_ERROR  = 3'd4,
      REPLY_ECHO   = 3'd5
   } reply_sel_type;

   typedef struct packed {
      logic          accept;
      logic          search_start;
      logic          idx_inc;
      logic          head_capture;
      logic          idx_to_tail;
      logic          idx_to_first;
      logic          sum_add;
      logic          reply_load;
      reply_sel_type reply_sel;
      logic          emit_payload;
      logic          emit_reply;
   } crl_cmd_type;

   typedef struct packed {
      logic req_close_frame;
      logic rd_is_head;
      logic rd_is_rec_head;
      logic rd_is_end;
      logic rd_is_echo;
      logic rd_is_tail;
      logic search_last;
      logic tail_fits;
      logic at_check;
      logic at_last_payload;
      logic sum_match;
      logic retry_ok;
      logic out_free;
      logic reply_last;
   } crl_status_type;

   function automatic logic closes_frame(input logic [7:0] b);
      return b == BYTE_REC_TAIL || b == BYTE_CLOSE_FC || b == BYTE_END ||
             b == BYTE_ECHO || b == BYTE_B8;
   endfunction

   function automatic logic is_head(input logic [7:0] b);
      return b == BYTE_REC_HEAD || b == BYTE_ALT_HEAD || b == BYTE_END ||
             b == BYTE_ECHO || b == BYTE_B8;
   endfunction

endpackage

@@ rtl/crl_ram.sv @@
module crl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/crl_ctrl.sv @@
module crl_ctrl
   import crl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  crl_status_type status,
   output crl_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_SRD   = 11'b000_0000_0010,
      S_SCHK  = 11'b000_0000_0100,
      S_TRD   = 11'b000_0000_1000,
      S_TCHK  = 11'b000_0001_0000,
      S_CRD   = 11'b000_0010_0000,
      S_CACC  = 11'b000_0100_0000,
      S_PRD   = 11'b000_1000_0000,
      S_PEMIT = 11'b001_0000_0000,
      S_REPLY = 11'b010_0000_0000,
      S_SPARE = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.reply_sel = REPLY_ERROR;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.req_close_frame) begin
               cmd.search_start = 1'b1;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (status.rd_is_head) begin
               cmd.head_capture = 1'b1;
               cmd.reply_load   = 1'b1;
               state_in = S_REPLY;
               if (status.rd_is_rec_head) begin
                  if (status.tail_fits) begin
                     cmd.reply_load  = 1'b0;
                     cmd.idx_to_tail = 1'b1;
                     state_in = S_TRD;
                  end
               end else if (status.rd_is_end) begin
                  cmd.reply_sel = REPLY_END;
               end else if (status.rd_is_echo) begin
                  cmd.reply_sel = REPLY_ECHO;
               end
            end else if (status.search_last) begin
               cmd.reply_load = 1'b1;
               state_in = S_REPLY;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = S_SRD;
            end
         end
         S_TRD: begin
            state_in = S_TCHK;
         end
         S_TCHK: begin
            if (status.rd_is_tail) begin
               cmd.idx_to_first = 1'b1;
               state_in = S_CRD;
            end else begin
               cmd.reply_load = 1'b1;
               state_in = S_REPLY;
            end
         end
         S_CRD: begin
            state_in = S_CACC;
         end
         S_CACC: begin
            // last read of the pass is the checksum byte itself
            if (status.at_check) begin
               cmd.reply_load = 1'b1;
               if (status.sum_match) begin
                  cmd.reply_sel    = REPLY_GOOD;
                  cmd.idx_to_first = 1'b1;
                  state_in = S_PRD;
               end else if (status.retry_ok) begin
                  cmd.reply_sel = REPLY_NAK;
                  state_in = S_REPLY;
               end else begin
                  cmd.reply_sel = REPLY_GIVEUP;
                  state_in = S_REPLY;
               end
            end else begin
               cmd.sum_add = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in = S_CRD;
            end
         end
         S_PRD: begin
            state_in = S_PEMIT;
         end
         S_PEMIT: begin
            if (status.out_free) begin
               cmd.emit_payload = 1'b1;
               if (status.at_last_payload) begin
                  state_in = S_REPLY;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = S_PRD;
               end
            end
         end
         S_REPLY: begin
            if (status.out_free) begin
               cmd.emit_reply = 1'b1;
               if (status.reply_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/crl_datapath.sv @@
module crl_datapath
   import crl_pkg::*;
#(
   parameter int FRAME_DEPTH   = FRAME_DEPTH_DEF,
   parameter int RECORD_LENGTH = RECORD_LENGTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  crl_cmd_type    cmd,
   output crl_status_type status,
   input  logic           req_operation,
   input  logic [7:0]     req_rx_byte,
   input  logic           csr_write_enable,
   input  logic           csr_index,
   input  logic [3:0]     csr_write_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_kind,
   output logic [7:0]     rsp_value,
   output logic [2:0]     rsp_frame_status,
   output logic [15:0]    rsp_record_count,
   output logic [15:0]    rsp_error_count,
   output logic           rsp_overflow,
   output logic           rsp_last
);

   localparam int AW = $clog2(FRAME_DEPTH);
   localparam int LW = $clog2(FRAME_DEPTH + 1);
   localparam int EW = LW + 1;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] head_ff, head_in;
   logic [6:0]    sum_ff, sum_in;
   logic [3:0]    retry_ff, retry_in;
   logic [15:0]   good_ff, good_in;
   logic [15:0]   bad_ff, bad_in;
   logic          ovf_ff, ovf_in;
   logic          end_mode_ff, end_mode_in;
   logic [3:0]    retry_limit_ff, retry_limit_in;

   logic [1:0]    rep_kind_ff, rep_kind_in;
   logic [7:0]    rep_value_ff, rep_value_in;
   logic [2:0]    rep_status_ff, rep_status_in;
   logic [3:0]    rep_cnt_ff, rep_cnt_in;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_kind_ff, out_kind_in;
   logic [7:0]    out_value_ff, out_value_in;
   logic [2:0]    out_status_ff, out_status_in;
   logic [15:0]   out_rec_ff, out_rec_in;
   logic [15:0]   out_err_ff, out_err_in;
   logic          out_ovf_ff, out_ovf_in;
   logic          out_last_ff, out_last_in;

   logic [7:0]    rd_data;
   logic          store_byte;
   logic          has_room;
   logic [EW-1:0] idx_ext;
   logic [EW-1:0] head_ext;
   logic [EW-1:0] tail_pos;
   logic          frame_done;

   assign has_room   = (len_ff < LW'(FRAME_DEPTH));
   assign store_byte = cmd.accept && (req_operation == OP_BYTE) && has_room;
   assign idx_ext    = EW'(idx_ff);
   assign head_ext   = EW'(head_ff);
   assign tail_pos   = idx_ext + EW'(RECORD_LENGTH - 1);
   assign frame_done = cmd.emit_reply && (rep_cnt_ff == 4'd1);

   crl_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_byte),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      status.req_close_frame = (req_operation == OP_BYTE) && closes_frame(req_rx_byte);
      status.rd_is_head      = is_head(rd_data);
      status.rd_is_rec_head  = (rd_data == BYTE_REC_HEAD);
      status.rd_is_end       = (rd_data == BYTE_END);
      status.rd_is_echo      = (rd_data == BYTE_ECHO);
      status.rd_is_tail      = (rd_data == BYTE_REC_TAIL);
      status.search_last     = (idx_ext + EW'(1)) >= EW'(len_ff);
      status.tail_fits       = tail_pos < EW'(len_ff);
      status.at_check        = idx_ext == (head_ext + EW'(RECORD_LENGTH - 2));
      status.at_last_payload = idx_ext == (head_ext + EW'(RECORD_LENGTH - 3));
      status.sum_match       = ({1'b0, sum_ff} == rd_data);
      status.retry_ok        = retry_ff < retry_limit_ff;
      status.out_free        = !out_valid_ff || rsp_ready;
      status.reply_last      = (rep_cnt_ff == 4'd1);
   end

   always_comb begin
      len_in         = len_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      sum_in         = sum_ff;
      retry_in       = retry_ff;
      good_in        = good_ff;
      bad_in         = bad_ff;
      ovf_in         = ovf_ff;
      end_mode_in    = end_mode_ff;
      retry_limit_in = retry_limit_ff;
      rep_kind_in    = rep_kind_ff;
      rep_value_in   = rep_value_ff;
      rep_status_in  = rep_status_ff;
      rep_cnt_in     = rep_cnt_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_END_MODE:    end_mode_in    = csr_write_data[0];
            CSR_RETRY_LIMIT: retry_limit_in = csr_write_data;
            default:         ;
         endcase
      end

      if (cmd.accept) begin
         if (req_operation == OP_SESSION) begin
            len_in   = '0;
            retry_in = '0;
            good_in  = '0;
            bad_in   = '0;
            ovf_in   = 1'b0;
         end else if (has_room) begin
            len_in = len_ff + LW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.search_start) begin
         idx_in = '0;
      end else if (cmd.idx_to_tail) begin
         idx_in = tail_pos[LW-1:0];
      end else if (cmd.idx_to_first) begin
         idx_in = head_ff + LW'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + LW'(1);
      end

      if (cmd.head_capture) begin
         head_in = idx_ff;
      end

      if (cmd.idx_to_first && !cmd.reply_load) begin
         sum_in = '0;
      end else if (cmd.sum_add) begin
         sum_in = sum_ff + rd_data[6:0];
      end

      if (cmd.reply_load) begin
         rep_kind_in = KIND_REPLY;
         rep_cnt_in  = 4'd1;
         case (cmd.reply_sel)
            REPLY_GOOD: begin
               rep_value_in  = BYTE_ACK;
               rep_status_in = FST_GOOD;
               retry_in      = '0;
               good_in       = (good_ff != 16'hffff) ? good_ff + 16'd1 : good_ff;
            end
            REPLY_NAK: begin
               rep_value_in  = BYTE_NAK;
               rep_status_in = FST_NAK;
               retry_in      = retry_ff + 4'd1;
            end
            REPLY_GIVEUP: begin
               rep_value_in  = BYTE_ACK;
               rep_status_in = FST_GIVEUP;
               retry_in      = '0;
               bad_in        = (bad_ff != 16'hffff) ? bad_ff + 16'd1 : bad_ff;
            end
            REPLY_END: begin
               rep_value_in  = end_mode_ff ? BYTE_END_IMM : BYTE_END_REPLY;
               rep_status_in = FST_END;
               rep_cnt_in    = END_REPLY_COUNT;
            end
            REPLY_ECHO: begin
               rep_kind_in   = KIND_STATUS;
               rep_value_in  = 8'h00;
               rep_status_in = FST_ECHO;
            end
            default: begin
               rep_value_in  = BYTE_ACK;
               rep_status_in = FST_ERROR;
               bad_in        = (bad_ff != 16'hffff) ? bad_ff + 16'd1 : bad_ff;
            end
         endcase
      end

      if (cmd.emit_reply) begin
         rep_cnt_in = rep_cnt_ff - 4'd1;
      end

      if (frame_done) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_rec_in    = out_rec_ff;
      out_err_in    = out_err_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit_payload || cmd.emit_reply) begin
         out_valid_in  = 1'b1;
         out_rec_in    = good_ff;
         out_err_in    = bad_ff;
         out_ovf_in    = ovf_ff;
         if (cmd.emit_payload) begin
            out_kind_in   = KIND_PAYLOAD;
            out_value_in  = rd_data;
            out_status_in = FST_GOOD;
            out_last_in   = 1'b0;
         end else begin
            out_kind_in   = rep_kind_ff;
            out_value_in  = rep_value_ff;
            out_status_in = rep_status_ff;
            out_last_in   = (rep_cnt_ff == 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= '0;
         retry_ff       <= '0;
         good_ff        <= '0;
         bad_ff         <= '0;
         ovf_ff         <= 1'b0;
         end_mode_ff    <= 1'b0;
         retry_limit_ff <= RETRY_LIMIT_RESET;
         rep_cnt_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         len_ff         <= len_in;
         retry_ff       <= retry_in;
         good_ff        <= good_in;
         bad_ff         <= bad_in;
         ovf_ff         <= ovf_in;
         end_mode_ff    <= end_mode_in;
         retry_limit_ff <= retry_limit_in;
         rep_cnt_ff     <= rep_cnt_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      head_ff       <= head_in;
      sum_ff        <= sum_in;
      rep_kind_ff   <= rep_kind_in;
      rep_value_ff  <= rep_value_in;
      rep_status_ff <= rep_status_in;
      out_kind_ff   <= out_kind_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_rec_ff    <= out_rec_in;
      out_err_ff    <= out_err_in;
      out_ovf_ff    <= out_ovf_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_record_count = out_rec_ff;
   assign rsp_error_count  = out_err_ff;
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_last         = out_last_ff;

endmodule

@@ rtl/call_record_link_receiver_top.sv @@
// Call record link receiver. Each req_ transaction carries one link byte (or, with
// operation set, a new-session command that clears the frame and the counters). A byte
// that does not close a frame is stored (or, with the store full, sets the overflow
// flag) and gives no results. A closing byte starts a walk over the frame store through
// its single registered read port: head search, then for a record a tail check and a
// checksum pass, then for a good record the payload bytes, then the replies at one per
// cycle while rsp_ready allows. Frames that are not good records skip the payload
// bytes. req_ready is low during this walk and while results wait on rsp_ready.
// Results leave through an output register, so the next byte is taken while the last
// result of a frame still waits. rsp_last marks the final result of a frame.
module call_record_link_receiver_top
   import crl_pkg::*;
#(
   parameter int FRAME_DEPTH   = FRAME_DEPTH_DEF,
   parameter int RECORD_LENGTH = RECORD_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic [2:0]  rsp_frame_status,
   output logic [15:0] rsp_record_count,
   output logic [15:0] rsp_error_count,
   output logic        rsp_overflow,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);

   crl_cmd_type    cmd;
   crl_status_type status;

   crl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crl_datapath #(
      .FRAME_DEPTH   (FRAME_DEPTH),
      .RECORD_LENGTH (RECORD_LENGTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_frame_status (rsp_frame_status),
      .rsp_record_count (rsp_record_count),
      .rsp_error_count  (rsp_error_count),
      .rsp_overflow     (rsp_overflow),
      .rsp_last         (rsp_last)
   );

endmodule
